@@ rtl/core/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 byte stream decoder.
`default_nettype none

package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 31;
  localparam int LEN_W  = 3;

  // Continuation byte is 10xxxxxx
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
  localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;
  localparam logic [BYTE_W-1:0] ASCII_LIMIT  = 8'h80;
  localparam logic [BYTE_W-1:0] BAD_LEAD_MIN = 8'hFE;

  // One decoded result
  typedef struct packed {
    logic             valid;
    logic             error;
    logic [LEN_W-1:0] seq_len;
    logic [CP_W-1:0]  code_point;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/utf8d_decode.sv @@
// Decode state and next-state logic: one byte per cycle while fire is high.
`default_nettype none

module utf8d_decode (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    fire,
  input  wire logic [utf8d_pkg::BYTE_W-1:0] data_byte,
  output utf8d_pkg::res_t              res
);
  import utf8d_pkg::*;

  logic [CP_W-1:0]  accumulator;
  logic [CP_W-1:0]  accumulator_next;
  logic [LEN_W-1:0] bytes_remaining;
  logic [LEN_W-1:0] bytes_remaining_next;
  logic [LEN_W-1:0] bytes_taken;
  logic [LEN_W-1:0] bytes_taken_next;
  logic             is_cont;
  logic [CP_W-1:0]  acc_shift;
  logic [LEN_W-1:0] taken_inc;

  assign is_cont   = (data_byte & CONT_MASK) == CONT_TAG;
  assign acc_shift = {accumulator[CP_W-7:0], data_byte[5:0] & PAYLOAD_MASK[5:0]};
  assign taken_inc = LEN_W'(bytes_taken + LEN_W'(1));

  // Next state and result for the current byte
  always_comb begin
    accumulator_next     = accumulator;
    bytes_remaining_next = bytes_remaining;
    bytes_taken_next     = bytes_taken;
    res                  = '0;
    if (bytes_remaining != '0) begin
      if (!is_cont) begin
        // missing continuation: drop partial sequence and this byte
        res.valid            = 1'b1;
        res.error            = 1'b1;
        res.seq_len          = taken_inc;
        accumulator_next     = '0;
        bytes_remaining_next = '0;
        bytes_taken_next     = '0;
      end else if (bytes_remaining == LEN_W'(1)) begin
        // final continuation byte completes the sequence
        res.valid            = 1'b1;
        res.seq_len          = taken_inc;
        res.code_point       = acc_shift;
        accumulator_next     = '0;
        bytes_remaining_next = '0;
        bytes_taken_next     = '0;
      end else begin
        accumulator_next     = acc_shift;
        bytes_remaining_next = LEN_W'(bytes_remaining - LEN_W'(1));
        bytes_taken_next     = taken_inc;
      end
    end else if (data_byte < ASCII_LIMIT) begin
      res.valid      = 1'b1;
      res.seq_len    = LEN_W'(1);
      res.code_point = CP_W'(data_byte);
    end else if (is_cont || data_byte >= BAD_LEAD_MIN) begin
      // stray continuation or invalid lead
      res.valid   = 1'b1;
      res.error   = 1'b1;
      res.seq_len = LEN_W'(1);
    end else begin
      // lead byte: leading ones set the length, payload below first zero
      bytes_taken_next = LEN_W'(1);
      priority if (!data_byte[5]) begin
        bytes_remaining_next = LEN_W'(1);
        accumulator_next     = CP_W'(data_byte & 8'h1F);
      end else if (!data_byte[4]) begin
        bytes_remaining_next = LEN_W'(2);
        accumulator_next     = CP_W'(data_byte & 8'h0F);
      end else if (!data_byte[3]) begin
        bytes_remaining_next = LEN_W'(3);
        accumulator_next     = CP_W'(data_byte & 8'h07);
      end else if (!data_byte[2]) begin
        bytes_remaining_next = LEN_W'(4);
        accumulator_next     = CP_W'(data_byte & 8'h03);
      end else begin
        bytes_remaining_next = LEN_W'(5);
        accumulator_next     = CP_W'(data_byte & 8'h01);
      end
    end
  end

  // Advance state only when a byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      bytes_remaining <= '0;
      bytes_taken     <= '0;
    end else if (fire) begin
      accumulator     <= accumulator_next;
      bytes_remaining <= bytes_remaining_next;
      bytes_taken     <= bytes_taken_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utf8d_out.sv @@
// Result register on the output channel.
`default_nettype none

module utf8d_out (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire logic            take,
  input  utf8d_pkg::res_t      res_in,
  output logic                 valid,
  output utf8d_pkg::res_t      res_q
);
  import utf8d_pkg::*;

  // Hold the result until taken; a new one may replace it in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utf8_byte_stream_decoder.sv @@
// UTF-8 byte stream decoder (1 to 6 byte sequences, 31-bit code points).
// Input channel s_*: one raw byte per item in s_tdata.
// Output channel m_*: one item per completed or malformed sequence;
//   m_tdata carries code_point and seq_len, m_tuser carries error.
// A byte lands in an input register; when it is consumed, it is decoded
// against the sequence state, and a result that it completes is loaded
// into the output register, which drives m_tdata.
// Lead bytes and inner continuation bytes give no item.
// Throughput is one byte per cycle while m_tready is high; the single
// decode step between input and output register sets that figure.
// When the receiver stalls, the held result stays put; the input register
// takes at most one more byte and then s_tready drops.
// Malformed input (stray continuation, missing continuation, lead byte
// 0xFE or 0xFF) gives an item with error set and code_point zero; the
// offending byte and any partial sequence are dropped.
// Reset clears the valid flags of both registers and returns the decoder to idle.
`default_nettype none

module utf8_byte_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [30:0] code_point, [33:31] seq_len, rest zero
  output logic             m_tuser    // [0] error
);
  import utf8d_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              consume;
  res_t              dec_res;
  res_t              out_res;

  // Consume the held byte when the result register is free or draining
  assign consume  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || consume;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  utf8d_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (consume),
    .data_byte (in_byte),
    .res       (dec_res)
  );

  utf8d_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (consume && dec_res.valid),
    .take   (m_tready),
    .res_in (dec_res),
    .valid  (m_tvalid),
    .res_q  (out_res)
  );

  assign m_tdata = {6'b0, out_res.seq_len, out_res.code_point};
  assign m_tuser = out_res.error;

`ifndef SYNTH
  // An error item never carries a code point
  a_err_zero_cp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[30:0] == '0)
    else $error("error item with nonzero code point");

  // Sequence length is always 1 to 6
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:31] != 3'd0 && m_tdata[33:31] != 3'd7)
    else $error("sequence length out of range");

  // An empty output register never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // A good one-byte item is plain ASCII
  a_err_len1_ascii: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && m_tdata[33:31] == 3'd1 |-> m_tdata[30:7] == '0)
    else $error("one-byte sequence above 0x7F");
`endif

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for the UTF-8 byte stream decoder: directed and random byte streams.
`timescale 1ns / 1ps

module tb;
  import utf8d_pkg::*;

  // One decoded result as it should leave the block
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             err;
  } cp_result_t;

  // Tracks the decoder state and holds the results still to come
  class code_point_tracker;
    logic [CP_W-1:0]  acc;
    logic [LEN_W-1:0] remaining;
    logic [LEN_W-1:0] taken;
    cp_result_t       pending_cps[$];
    int               fails;
    int               bytes_in;
    int               results_seen;
    int               bad_seqs;

    function new();
      acc = '0;
      remaining = '0;
      taken = '0;
      fails = 0;
      bytes_in = 0;
      results_seen = 0;
      bad_seqs = 0;
    endfunction

    function int pending();
      return pending_cps.size();
    endfunction

    function void push_result(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len, logic err);
      cp_result_t r;
      r.cp = cp;
      r.len = len;
      r.err = err;
      pending_cps.push_back(r);
      acc = '0;
      remaining = '0;
      taken = '0;
    endfunction

    // Advance the decoder by one accepted byte
    function void take_byte(logic [BYTE_W-1:0] b);
      int ones;
      bytes_in++;
      if (remaining != 0) begin
        if ((b & CONT_MASK) != CONT_TAG) begin
          // missing continuation: drop partial sequence and this byte
          push_result('0, taken + 3'd1, 1'b1);
        end else begin
          acc = {acc[CP_W-7:0], b[5:0]};
          taken = taken + 3'd1;
          remaining = remaining - 3'd1;
          if (remaining == 0)
            push_result(acc, taken, 1'b0);
        end
      end else if (b < ASCII_LIMIT) begin
        push_result({23'd0, b}, 3'd1, 1'b0);
      end else if ((b & CONT_MASK) == CONT_TAG || b >= BAD_LEAD_MIN) begin
        // stray continuation or invalid lead
        push_result('0, 3'd1, 1'b1);
      end else begin
        // open a sequence: payload lies below the first zero
        ones = 0;
        while (ones < 8 && b[7-ones])
          ones++;
        acc = {23'd0, b & (8'hFF >> (ones + 1))};
        taken = 3'd1;
        remaining = 3'(ones - 1);
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void match_code_point(logic [39:0] tdata, logic tuser);
      cp_result_t e;
      if (pending_cps.size() == 0) begin
        $display("%0t: unexpected result cp=%h len=%0d err=%b", $time,
                 tdata[30:0], tdata[33:31], tuser);
        fails++;
        return;
      end
      e = pending_cps.pop_front();
      results_seen++;
      if (e.err)
        bad_seqs++;
      if (tdata[30:0] !== e.cp) begin
        $display("%0t: code_point expected %h actual %h", $time, e.cp, tdata[30:0]);
        fails++;
      end
      if (tdata[33:31] !== e.len) begin
        $display("%0t: seq_len expected %0d actual %0d", $time, e.len, tdata[33:31]);
        fails++;
      end
      if (tuser !== e.err) begin
        $display("%0t: error expected %b actual %b", $time, e.err, tuser);
        fails++;
      end
      if (tdata[39:34] !== 6'd0) begin
        $display("%0t: tdata padding expected 0 actual %h", $time, tdata[39:34]);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  code_point_tracker tracker;
  int                sent_count = 0;
  logic              send_burst = 1'b0;

  utf8_byte_stream_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (sent_count % 64 == 0)
      send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    tracker.take_byte(b);
    sent_count++;
  endtask

  function automatic logic [7:0] lead_byte(int len);
    if (len == 1)
      return 8'($urandom_range(0, 127));
    return (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] non_cont_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while ((b & CONT_MASK) == CONT_TAG)
      b = 8'($urandom);
    return b;
  endfunction

  // Well-formed sequence of the given length with random payload
  task automatic send_sequence(input int len);
    send_byte(lead_byte(len));
    for (int i = 1; i < len; i++)
      send_byte(cont_byte());
  endtask

  // Sequence cut short by a byte that is not a continuation
  task automatic send_broken(input int len);
    int keep;
    keep = $urandom_range(0, len - 2);
    send_byte(lead_byte(len));
    for (int i = 0; i < keep; i++)
      send_byte(cont_byte());
    send_byte(non_cont_byte());
  endtask

  // Receiver: random stalls, one long hold-off to back the block up
  initial begin
    int gap;
    int got;
    logic burst;
    got = 0;
    burst = 1'b0;
    wait (!rst);
    forever begin
      if (got % 64 == 0)
        burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 10);
      if (got == 60)
        gap = 300;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.match_code_point(m_tdata, m_tuser);
      got++;
    end
  end

  initial begin
    int pick;
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ASCII ends, stray continuations, invalid leads
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hBF);
    send_byte(8'hFE);
    send_byte(8'hFF);
    // two-byte maximum
    send_byte(8'hDF);
    send_byte(8'hBF);
    // six-byte maximum, 31-bit code point of all ones
    send_byte(8'hFD);
    repeat (5) send_byte(8'hBF);
    // four-byte sequence
    send_byte(8'hF4);
    send_byte(8'h8F);
    send_byte(8'hBF);
    send_byte(8'hBF);
    // missing continuation after a five-byte lead
    send_byte(8'hF8);
    send_byte(8'h41);
    // a new lead inside an open sequence is dropped, not reread
    send_byte(8'hC2);
    send_byte(8'hC2);
    // invalid lead byte as the breaking byte
    send_byte(8'hE0);
    send_byte(8'h80);
    send_byte(8'hFF);

    // Random: mostly well-formed sequences, some broken ones and noise
    while (sent_count < 850) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        send_sequence(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6));
      else if (pick < 90)
        send_broken($urandom_range(2, 6));
      else
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
    s_tvalid <= 1'b0;

    // Drain, then keep running to catch stray results
    while (tracker.pending() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Decoded %0d bytes into %0d checked results, %0d of them malformed.",
             tracker.bytes_in, tracker.results_seen, tracker.bad_seqs);
    $display("Stream held sequences of every length with long receiver back-pressure.");
    if (tracker.fails == 0 && tracker.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", tracker.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_decode.sv
rtl/core/utf8d_out.sv
rtl/core/utf8_byte_stream_decoder.sv
test/tb.sv
